// ----- rtl/lat_pkg.sv -----
// Shared types and constants for the toroidal life grid.
`timescale 1ns / 1ps
package lat_pkg;

  // Grid geometry: up to 32 rows of 32 cells.
  localparam int unsigned GridDim = 32;
  localparam int unsigned IdxW    = $clog2(GridDim);
  localparam int unsigned SizeW   = IdxW + 1;

  localparam logic [SizeW-1:0] SizeReset = SizeW'(GridDim);

  typedef logic [GridDim-1:0] row_t;

  // Request codes carried by an input item.
  typedef enum logic [1:0] {
    ReqSet   = 2'd0,
    ReqClear = 2'd1,
    ReqStep  = 2'd2,
    ReqRead  = 2'd3
  } req_e;

  // Per-cell control from the sequencer.
  typedef struct packed {
    logic shift;     // rotate the ring one place this cycle
    logic tail;      // this cell takes the freshly computed row
    logic wr_en;     // single-cell write to this row
    logic wr_alive;  // value written by a single-cell write
  } cell_ctrl_t;

endpackage

// ----- rtl/lat_cell.sv -----
// One row cell of the ring: holds a grid row and passes it to its neighbor.
`timescale 1ns / 1ps
module lat_cell
  import lat_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  row_t             nbr_row_i,
  input  row_t             new_row_i,
  input  logic [IdxW-1:0]  wr_col_i,
  output row_t             row_o
);

  row_t row_q, row_d;

  // During a sweep the row moves toward the head; otherwise single cells are written.
  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = ctrl_i.tail ? new_row_i : nbr_row_i;
    end else if (ctrl_i.wr_en) begin
      row_d[wr_col_i] = ctrl_i.wr_alive;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else begin
      row_q <= row_d;
    end
  end

  assign row_o = row_q;

endmodule

// ----- rtl/lat_rule.sv -----
// Next-generation row from three old rows, wrapping columns at the active size.
`timescale 1ns / 1ps
module lat_rule
  import lat_pkg::*;
(
  input  row_t             up_i,
  input  row_t             mid_i,
  input  row_t             dn_i,
  input  logic [IdxW-1:0]  last_col_i,
  output row_t             new_row_o
);

  for (genvar c = 0; c < GridDim; c++) begin : g_col
    logic       up_l, up_r, mid_l, mid_r, dn_l, dn_r;
    logic       wrap_r;
    logic [3:0] cnt;
    logic       alive_next;

    // Left neighbor wraps to the last active column.
    if (c == 0) begin : g_left_wrap
      assign up_l  = up_i[last_col_i];
      assign mid_l = mid_i[last_col_i];
      assign dn_l  = dn_i[last_col_i];
    end else begin : g_left
      assign up_l  = up_i[c-1];
      assign mid_l = mid_i[c-1];
      assign dn_l  = dn_i[c-1];
    end

    // Right neighbor of the last active column is column zero.
    if (c == GridDim - 1) begin : g_right_end
      assign wrap_r = 1'b1;
      assign up_r   = up_i[0];
      assign mid_r  = mid_i[0];
      assign dn_r   = dn_i[0];
    end else begin : g_right
      assign wrap_r = (last_col_i == IdxW'(c));
      assign up_r   = wrap_r ? up_i[0]  : up_i[c+1];
      assign mid_r  = wrap_r ? mid_i[0] : mid_i[c+1];
      assign dn_r   = wrap_r ? dn_i[0]  : dn_i[c+1];
    end

    // Neighbor count and the B3/S23 rule; inactive columns keep their value.
    assign cnt = {3'b000, up_l} + {3'b000, up_i[c]} + {3'b000, up_r}
               + {3'b000, mid_l} + {3'b000, mid_r}
               + {3'b000, dn_l} + {3'b000, dn_i[c]} + {3'b000, dn_r};
    assign alive_next = (cnt == 4'd3) || (mid_i[c] && (cnt == 4'd2));
    assign new_row_o[c] = (IdxW'(c) <= last_col_i) ? alive_next : mid_i[c];
  end

endmodule

// ----- rtl/life_automaton_torus_grid.sv -----
// Top level: ring of row cells, generation sequencer and result register.
// A cell write or row read loads the result register when it is accepted.
// A generation sweeps each active row (active size 1..32) in turn through the ring's
// single rule unit, then loads its result once the result channel can take it.
// Throughput: one item at a time; reads and writes, one item per cycle if unstalled.
// Reset (rst_ni low, asynchronous) clears all cells to dead and sets the size to 32.
`timescale 1ns / 1ps
module life_automaton_torus_grid
  import lat_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration write channel.
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [SizeW-1:0]  grid_size_i,
  // Request channel.
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [IdxW-1:0]   row_i,
  input  logic [IdxW-1:0]   col_i,
  // Result channel.
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [31:0]       row_bits_o,
  output logic              ignored_o
);

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StSweep = 3'b010,
    StDone  = 3'b100
  } state_e;

  state_e            state_q, state_d;
  logic [SizeW-1:0]  grid_size_q;
  logic [SizeW-1:0]  size_n;
  logic [IdxW-1:0]   last_idx;
  logic [IdxW-1:0]   k_q, k_d;
  row_t              prev_q, prev_d;
  row_t              row0_q, row0_d;
  row_t              rows [GridDim];
  row_t              new_row;
  row_t              dn_row;
  row_t              rd_row;
  row_t              col_mask;
  logic [IdxW-1:0]   rd_addr;
  logic              can_load;
  logic              in_fire;
  logic              is_write;
  logic              row_ok;
  logic              col_ok;
  logic              sweep_last;
  logic              out_valid_q, out_valid_d;
  logic [31:0]       out_bits_q, out_bits_d;
  logic              out_ign_q, out_ign_d;
  logic              out_load;

  // Configuration register, always writable.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= SizeReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grid_size_q <= grid_size_i;
    end
  end

  // Active size clamped to 1..GridDim.
  always_comb begin
    size_n = grid_size_q;
    if (grid_size_q == '0) begin
      size_n = SizeW'(1);
    end else if (grid_size_q > SizeW'(GridDim)) begin
      size_n = SizeW'(GridDim);
    end
  end
  assign last_idx = IdxW'(size_n - SizeW'(1));

  for (genvar c = 0; c < GridDim; c++) begin : g_mask
    assign col_mask[c] = (SizeW'(c) < size_n);
  end

  // Input handshake.
  assign can_load   = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == StIdle) && can_load);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign is_write   = (req_type_i == ReqSet) || (req_type_i == ReqClear);
  assign row_ok     = ({1'b0, row_i} < size_n);
  assign col_ok     = ({1'b0, col_i} < size_n);

  // Single read tap: the requested row, or the last active row at a generation start.
  assign rd_addr = (req_type_i == ReqStep) ? last_idx : row_i;
  assign rd_row  = rows[rd_addr];

  // Rule unit at the head of the ring.
  assign sweep_last = (k_q == last_idx);
  assign dn_row     = sweep_last ? row0_q : rows[1];

  lat_rule u_rule (
    .up_i       (prev_q),
    .mid_i      (rows[0]),
    .dn_i       (dn_row),
    .last_col_i (last_idx),
    .new_row_o  (new_row)
  );

  // Ring of row cells; the active part rotates toward cell 0 during a sweep.
  for (genvar j = 0; j < GridDim; j++) begin : g_cell
    cell_ctrl_t ctrl;
    row_t       nbr;

    assign ctrl.shift    = (state_q == StSweep) && (SizeW'(j) < size_n);
    assign ctrl.tail     = (last_idx == IdxW'(j));
    assign ctrl.wr_en    = in_fire && is_write && row_ok && col_ok && (row_i == IdxW'(j));
    assign ctrl.wr_alive = (req_type_i == ReqSet);
    assign nbr           = rows[(j + 1) % GridDim];

    lat_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .nbr_row_i (nbr),
      .new_row_i (new_row),
      .wr_col_i  (col_i),
      .row_o     (rows[j])
    );
  end

  // Generation sequencer.
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    prev_d  = prev_q;
    row0_d  = row0_q;
    case (state_q)
      StIdle: begin
        if (in_fire && (req_type_i == ReqStep)) begin
          prev_d  = rd_row;
          row0_d  = rows[0];
          k_d     = '0;
          state_d = StSweep;
        end
      end
      StSweep: begin
        prev_d = rows[0];
        k_d    = k_q + IdxW'(1);
        if (sweep_last) begin
          state_d = StDone;
        end
      end
      StDone: begin
        if (can_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    row0_q <= row0_d;
  end

  // Result register: loaded by writes and reads at acceptance, by a generation at its end.
  always_comb begin
    out_load   = 1'b0;
    out_bits_d = out_bits_q;
    out_ign_d  = out_ign_q;
    if (in_fire && (req_type_i != ReqStep)) begin
      out_load = 1'b1;
      if (is_write) begin
        out_bits_d = '0;
        out_ign_d  = !(row_ok && col_ok);
      end else begin
        out_bits_d = row_ok ? 32'(rd_row & col_mask) : '0;
        out_ign_d  = !row_ok;
      end
    end else if ((state_q == StDone) && can_load) begin
      out_load   = 1'b1;
      out_bits_d = '0;
      out_ign_d  = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bits_q <= out_bits_d;
    out_ign_q  <= out_ign_d;
  end

  assign out_valid_o = out_valid_q;
  assign row_bits_o  = out_bits_q;
  assign ignored_o   = out_ign_q;

`ifndef ASSERT_OFF
  // The sweep counter never runs past the last active row.
  a_sweep_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StSweep) |-> (k_q <= last_idx))
    else $error("sweep counter beyond active size");

  // An accepted generation starts the sweep on the next cycle.
  a_step_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i == ReqStep)) |=> (state_q == StSweep))
    else $error("generation did not start a sweep");

  // A write or read item presents its result on the next cycle.
  a_direct_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (req_type_i != ReqStep)) |=> (out_valid_o && (state_q == StIdle)))
    else $error("write or read result missing");

  // The end of a generation yields one clean result and returns to idle.
  a_step_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StDone) && can_load) |=>
      (out_valid_o && !ignored_o && (row_bits_o == '0) && (state_q == StIdle)))
    else $error("generation result malformed");
`endif

endmodule
